// File: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk_i, switched off while rst_ni is low.
`define SLCP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication under the same clock and reset.
`define SLCP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under the same clock and reset.
`define SLCP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/slcp_pkg.sv
`default_nettype none

package slcp_pkg;

  // Command codes of a result beat.
  localparam logic [1:0] CMD_HISTORY  = 2'd0;
  localparam logic [1:0] CMD_ALARMS   = 2'd1;
  localparam logic [1:0] CMD_SETPOINT = 2'd2;
  localparam logic [1:0] CMD_UNKNOWN  = 2'd3;

  // Characters with a special meaning.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Prefixes, first character in the top byte. The alarm prefix is padded.
  localparam logic [63:0] PFX_HIST  = "HISTORY:";
  localparam logic [63:0] PFX_ALARM = {"ALARMS", 16'h0000};
  localparam logic [63:0] PFX_CMD   = "COMMAND:";
  localparam int unsigned PFX_LONG  = 8;
  localparam int unsigned PFX_SHORT = 6;

  // Scan control from the sequencer to the parser.
  typedef struct packed {
    logic       clear;    // start of a new line scan
    logic       step;     // byte_i holds a stored byte
    logic       pre_act;  // byte lies in the prefix window
    logic [2:0] pre_idx;  // position inside the prefix window
    logic       len_ge6;  // line is long enough for the short prefix
    logic       len_ge8;  // line is long enough for the long prefixes
  } slcp_ctl_t;

  // One decoded line.
  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] day_count;
    logic [7:0]  setpoint_whole;
    logic [6:0]  setpoint_hundredths;
  } slcp_res_t;

  // Character of a prefix at a position.
  function automatic logic [7:0] pfx_char(input logic [63:0] pfx, input logic [2:0] idx);
    return pfx[{~idx, 3'b000} +: 8];
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/slcp_if.sv
`default_nettype none

// Received byte channel.
interface slcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Decoded line channel.
interface slcp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [15:0] day_count;
  logic [7:0]         setpoint_whole;
  logic [6:0]         setpoint_hundredths;

  modport source (output valid, output command, output day_count,
                  output setpoint_whole, output setpoint_hundredths, input ready);
  modport sink (input valid, input command, input day_count,
                input setpoint_whole, input setpoint_hundredths, output ready);
endinterface

`default_nettype wire

// File: rtl/core/slcp_line_mem.sv
`default_nettype none

module slcp_line_mem #(
  parameter int Depth = 128,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [7:0]       wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];

  // One write port, one read port with registered data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/slcp_parse.sv
`default_nettype none

module slcp_parse
  import slcp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire slcp_ctl_t ctl_i,
  input  wire logic [7:0] byte_i,
  output slcp_res_t      res_o
);

  // Number parser phases.
  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_INT  = 2'd1;
  localparam logic [1:0] PH_FRAC = 2'd2;
  localparam logic [1:0] PH_STOP = 2'd3;

  logic [1:0]  ph_q, ph_d;
  logic        neg_q, neg_d;
  logic [15:0] mag_q, mag_d;
  logic [8:0]  whole_q, whole_d;
  logic        fk_q, fk_d;
  logic [3:0]  ht_q, ht_d;
  logic [3:0]  hu_q, hu_d;
  logic        mh_q, mh_d;
  logic        ma_q, ma_d;
  logic        mc_q, mc_d;

  logic [3:0]  dig;
  logic        isd;
  logic [19:0] mag_mul;
  logic [15:0] mag_sat;
  logic [12:0] whole_mul;
  logic [8:0]  whole_sat;

  // Decimal accumulate with saturation, day count and setpoint in parallel.
  assign dig       = 4'(byte_i - CH_ZERO);
  assign isd       = is_digit(byte_i);
  assign mag_mul   = 20'({mag_q, 3'b000}) + 20'({mag_q, 1'b0}) + 20'(dig);
  assign mag_sat   = (mag_mul > 20'd32768) ? 16'h8000 : mag_mul[15:0];
  assign whole_mul = 13'({whole_q, 3'b000}) + 13'({whole_q, 1'b0}) + 13'(dig);
  assign whole_sat = (whole_mul > 13'd256) ? 9'd256 : whole_mul[8:0];

  // Per-byte update of prefix match flags and number state.
  always_comb begin
    ph_d    = ph_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    whole_d = whole_q;
    fk_d    = fk_q;
    ht_d    = ht_q;
    hu_d    = hu_q;
    mh_d    = mh_q;
    ma_d    = ma_q;
    mc_d    = mc_q;
    if (ctl_i.clear) begin
      ph_d    = PH_LEAD;
      neg_d   = 1'b0;
      mag_d   = '0;
      whole_d = '0;
      fk_d    = 1'b0;
      ht_d    = '0;
      hu_d    = '0;
      mh_d    = 1'b1;
      ma_d    = 1'b1;
      mc_d    = 1'b1;
    end else if (ctl_i.step) begin
      if (ctl_i.pre_act) begin
        mh_d = mh_q && (byte_i == pfx_char(PFX_HIST, ctl_i.pre_idx));
        mc_d = mc_q && (byte_i == pfx_char(PFX_CMD, ctl_i.pre_idx));
        if (ctl_i.pre_idx < 3'(PFX_SHORT)) begin
          ma_d = ma_q && (byte_i == pfx_char(PFX_ALARM, ctl_i.pre_idx));
        end
      end else begin
        case (ph_q)
          PH_LEAD: begin
            if (is_blank(byte_i)) begin
              ph_d = PH_LEAD;
            end else if (byte_i == CH_PLUS || byte_i == CH_MINUS) begin
              neg_d = (byte_i == CH_MINUS);
              ph_d  = PH_INT;
            end else if (isd) begin
              mag_d   = mag_sat;
              whole_d = whole_sat;
              ph_d    = PH_INT;
            end else if (byte_i == CH_DOT) begin
              ph_d = PH_FRAC;
            end else begin
              ph_d = PH_STOP;
            end
          end
          PH_INT: begin
            if (isd) begin
              mag_d   = mag_sat;
              whole_d = whole_sat;
            end else if (byte_i == CH_DOT) begin
              ph_d = PH_FRAC;
            end else begin
              ph_d = PH_STOP;
            end
          end
          PH_FRAC: begin
            if (!isd) begin
              ph_d = PH_STOP;
            end else if (!fk_q) begin
              ht_d = dig;
              fk_d = 1'b1;
            end else begin
              hu_d = dig;
              ph_d = PH_STOP;
            end
          end
          default: begin
            ph_d = PH_STOP;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_LEAD;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      whole_q <= '0;
      fk_q    <= 1'b0;
      ht_q    <= '0;
      hu_q    <= '0;
      mh_q    <= 1'b0;
      ma_q    <= 1'b0;
      mc_q    <= 1'b0;
    end else begin
      ph_q    <= ph_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
      whole_q <= whole_d;
      fk_q    <= fk_d;
      ht_q    <= ht_d;
      hu_q    <= hu_d;
      mh_q    <= mh_d;
      ma_q    <= ma_d;
      mc_q    <= mc_d;
    end
  end

  // Result of the finished scan, prefixes checked in priority order.
  logic       hist_hit, alarm_hit, cmd_hit;
  logic [6:0] hund;

  assign hist_hit  = mh_q && ctl_i.len_ge8;
  assign alarm_hit = ma_q && ctl_i.len_ge6;
  assign cmd_hit   = mc_q && ctl_i.len_ge8;
  assign hund      = 7'({ht_q, 3'b000}) + 7'({ht_q, 1'b0}) + 7'(hu_q);

  always_comb begin
    res_o = '0;
    if (hist_hit) begin
      res_o.command = CMD_HISTORY;
      if (neg_q) begin
        res_o.day_count = 16'(~mag_q + 16'd1);
      end else if (mag_q > 16'd32767) begin
        res_o.day_count = 16'd32767;
      end else begin
        res_o.day_count = mag_q;
      end
    end else if (alarm_hit) begin
      res_o.command = CMD_ALARMS;
    end else if (cmd_hit) begin
      res_o.command = CMD_SETPOINT;
      if (neg_q) begin
        res_o.setpoint_whole      = '0;
        res_o.setpoint_hundredths = '0;
      end else if (whole_q > 9'd255) begin
        res_o.setpoint_whole      = 8'd255;
        res_o.setpoint_hundredths = 7'd99;
      end else begin
        res_o.setpoint_whole      = whole_q[7:0];
        res_o.setpoint_hundredths = hund;
      end
    end else begin
      res_o.command = CMD_UNKNOWN;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/serial_line_command_parser.sv
// Channel   Dir  Fields                                              Accept
// rx_i      in   rx_byte[7:0]                                        valid & ready
// res_o     out  command[1:0] day_count[15:0] setpoint_whole[7:0]    valid & ready
//                setpoint_hundredths[6:0]
//
// A byte other than newline is taken and, unless it is zero or the line is full, written to the line memory.
// After a newline beat, input ready stays low while the stored bytes are read back one per cycle
// and the result is loaded.
// The last scan cycle waits until the output register is free.
// Reset clears the fill count, the sequencer and the output valid; the memory is not cleared.
// Results wait in the output register while further bytes of the next line are taken.
`default_nettype none

module serial_line_command_parser
  import slcp_pkg::*;
#(
  parameter int LINE_CAPACITY = 128
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  slcp_in_if.sink     rx_i,
  slcp_out_if.source  res_o
);

  localparam int CntW = $clog2(LINE_CAPACITY);
  localparam logic [CntW-1:0] LastFill = CntW'(LINE_CAPACITY - 1);

  // Sequencer states.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic            st_q, st_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] rd_pos_q;
  logic            rd_vld_q;
  logic            out_vld_q, out_vld_d;
  slcp_res_t       res_q;

  logic            acc, is_nl, wr_en, rd_en, finish, out_free;
  logic [7:0]      rd_data;
  slcp_ctl_t       ctl;
  slcp_res_t       res_new;

  assign rx_i.ready = (st_q == ST_IDLE);
  assign acc        = rx_i.valid && rx_i.ready;
  assign is_nl      = (rx_i.rx_byte == CH_NL);
  assign out_free   = !out_vld_q || res_o.ready;

  // Store a byte while the line has room; zero bytes are dropped.
  assign wr_en = acc && !is_nl && (rx_i.rx_byte != CH_NUL) && (fill_q != LastFill);

  // Read back one stored byte per cycle during the scan.
  assign rd_en  = (st_q == ST_SCAN) && (rd_ptr_q != fill_q);
  assign finish = (st_q == ST_SCAN) && !rd_en && !rd_vld_q && out_free;

  slcp_line_mem #(
    .Depth (LINE_CAPACITY),
    .AddrW (CntW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (fill_q),
    .wdata_i (rx_i.rx_byte),
    .re_i    (rd_en),
    .raddr_i (rd_ptr_q),
    .rdata_o (rd_data)
  );

  // Parser control for the byte returning from memory.
  always_comb begin
    ctl         = '0;
    ctl.clear   = acc && is_nl;
    ctl.step    = rd_vld_q;
    ctl.pre_act = (rd_pos_q < CntW'(PFX_LONG));
    ctl.pre_idx = rd_pos_q[2:0];
    ctl.len_ge6 = (fill_q >= CntW'(PFX_SHORT));
    ctl.len_ge8 = (fill_q >= CntW'(PFX_LONG));
  end

  slcp_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .byte_i (rd_data),
    .res_o  (res_new)
  );

  // Sequencer, fill count and output valid.
  always_comb begin
    st_d      = st_q;
    fill_d    = fill_q;
    rd_ptr_d  = rd_ptr_q;
    out_vld_d = out_vld_q && !res_o.ready;
    case (st_q)
      ST_IDLE: begin
        if (wr_en) begin
          fill_d = fill_q + CntW'(1);
        end
        if (acc && is_nl) begin
          st_d     = ST_SCAN;
          rd_ptr_d = '0;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          rd_ptr_d = rd_ptr_q + CntW'(1);
        end
        if (finish) begin
          st_d      = ST_IDLE;
          fill_d    = '0;
          out_vld_d = 1'b1;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      fill_q    <= '0;
      rd_ptr_q  <= '0;
      rd_pos_q  <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      fill_q    <= fill_d;
      rd_ptr_q  <= rd_ptr_d;
      rd_pos_q  <= rd_ptr_q;
      rd_vld_q  <= rd_en;
      out_vld_q <= out_vld_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (finish) begin
      res_q <= res_new;
    end
  end

  assign res_o.valid               = out_vld_q;
  assign res_o.command             = res_q.command;
  assign res_o.day_count           = res_q.day_count;
  assign res_o.setpoint_whole      = res_q.setpoint_whole;
  assign res_o.setpoint_hundredths = res_q.setpoint_hundredths;

endmodule

`default_nettype wire

// File: rtl/core/slcp_checker.sv
`default_nettype none
`include "assert_macros.svh"

module slcp_checker
  import slcp_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [1:0]  command_i,
  input wire logic [15:0] day_count_i,
  input wire logic [7:0]  setpoint_whole_i,
  input wire logic [6:0]  setpoint_hundredths_i
);

  // A stalled result beat keeps its payload.
  `SLCP_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(command_i) && $stable(day_count_i) && $stable(setpoint_whole_i) && $stable(setpoint_hundredths_i), "stalled result changed")

  // Only a history line carries a day count.
  `SLCP_ASSERT_IMP(a_days_zero, out_valid_i && (command_i != CMD_HISTORY), day_count_i == 16'd0, "day count outside history")

  // Only a setpoint line carries setpoint fields.
  `SLCP_ASSERT_IMP(a_set_zero, out_valid_i && (command_i != CMD_SETPOINT), (setpoint_whole_i == 8'd0) && (setpoint_hundredths_i == 7'd0), "setpoint outside command")

  // Hundredths stay within two decimal digits.
  `SLCP_ASSERT(a_hund_range, !out_valid_i || (setpoint_hundredths_i <= 7'd99), "hundredths out of range")

endmodule

bind serial_line_command_parser slcp_checker u_slcp_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .out_valid_i           (res_o.valid),
  .out_ready_i           (res_o.ready),
  .command_i             (res_o.command),
  .day_count_i           (res_o.day_count),
  .setpoint_whole_i      (res_o.setpoint_whole),
  .setpoint_hundredths_i (res_o.setpoint_hundredths)
);

`default_nettype wire

// File: sim/tb_serial_line_command_parser.sv
module tb_serial_line_command_parser;
  import slcp_pkg::*;

  localparam int LINE_CAPACITY  = 128;
  localparam int RANDOM_BYTES   = 1100;
  localparam int CALM_BYTES     = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 2 * LINE_CAPACITY + 16;

  // One directed line: text, optional typed-in result, padding and zero-byte mixing.
  typedef struct {
    string      text;
    bit         typed;
    slcp_res_t  want;
    logic [7:0] pad;
    int         pad_to;
    bit         nul_mix;
  } line_case_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  slcp_in_if  rx_if ();
  slcp_out_if res_if ();

  serial_line_command_parser #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the line being received and the decoded lines still due.
  logic [7:0] line_bytes [LINE_CAPACITY];
  int         line_len = 0;
  slcp_res_t  decoded_due [$];

  // A typed-in result that replaces the predicted one for the next newline.
  slcp_res_t  pinned_res;
  bit         pinned_valid = 1'b0;

  int  mismatches   = 0;
  int  quiet_cycles = 0;
  int  bytes_sent   = 0;
  int  stall_left   = 0;
  bit  calm_tail    = 1'b0;

  line_case_t line_cases [28] = '{
    '{"",                 1'b1, '{CMD_UNKNOWN,  16'd0,      8'd0,   7'd0},  8'h00, 0, 1'b0},
    '{"HISTORY:",         1'b1, '{CMD_HISTORY,  16'd0,      8'd0,   7'd0},  8'h00, 0, 1'b0},
    '{"HISTORY:32767",    1'b1, '{CMD_HISTORY,  16'd32767,  8'd0,   7'd0},  8'h00, 0, 1'b0},
    // Most negative day count.
    '{"HISTORY:-32768",   1'b1, '{CMD_HISTORY,  16'h8000,   8'd0,   7'd0},  8'h00, 0, 1'b0},
    '{"HISTORY:999999",   1'b1, '{CMD_HISTORY,  16'd32767,  8'd0,   7'd0},  8'h00, 0, 1'b0},
    '{"HISTORY: \011\013\014\015-123abc",
                          1'b1, '{CMD_HISTORY,  -16'sd123,  8'd0,   7'd0},  8'h00, 0, 1'b0},
    '{"HISTORY:+12",      1'b1, '{CMD_HISTORY,  16'd12,     8'd0,   7'd0},  8'h00, 0, 1'b0},
    '{"HISTORY:-99999",   1'b1, '{CMD_HISTORY,  16'h8000,   8'd0,   7'd0},  8'h00, 0, 1'b0},
    '{"HISTORY",          1'b1, '{CMD_UNKNOWN,  16'd0,      8'd0,   7'd0},  8'h00, 0, 1'b0},
    '{"ALARMS",           1'b1, '{CMD_ALARMS,   16'd0,      8'd0,   7'd0},  8'h00, 0, 1'b0},
    '{"ALARMS 12",        1'b1, '{CMD_ALARMS,   16'd0,      8'd0,   7'd0},  8'h00, 0, 1'b0},
    '{"ALARM",            1'b1, '{CMD_UNKNOWN,  16'd0,      8'd0,   7'd0},  8'h00, 0, 1'b0},
    '{"COMMAND:21.5",     1'b1, '{CMD_SETPOINT, 16'd0,      8'd21,  7'd50}, 8'h00, 0, 1'b0},
    '{"COMMAND:255.999",  1'b1, '{CMD_SETPOINT, 16'd0,      8'd255, 7'd99}, 8'h00, 0, 1'b0},
    '{"COMMAND:256",      1'b1, '{CMD_SETPOINT, 16'd0,      8'd255, 7'd99}, 8'h00, 0, 1'b0},
    '{"COMMAND:-0.5",     1'b1, '{CMD_SETPOINT, 16'd0,      8'd0,   7'd0},  8'h00, 0, 1'b0},
    '{"COMMAND: +7.0",    1'b1, '{CMD_SETPOINT, 16'd0,      8'd7,   7'd0},  8'h00, 0, 1'b0},
    '{"COMMAND:1e3",      1'b1, '{CMD_SETPOINT, 16'd0,      8'd1,   7'd0},  8'h00, 0, 1'b0},
    '{"COMMAND:.75",      1'b1, '{CMD_SETPOINT, 16'd0,      8'd0,   7'd75}, 8'h00, 0, 1'b0},
    '{"COMMAND:0x1F",     1'b1, '{CMD_SETPOINT, 16'd0,      8'd0,   7'd0},  8'h00, 0, 1'b0},
    '{"\377\200COMMAND:1", 1'b1, '{CMD_UNKNOWN, 16'd0,      8'd0,   7'd0},  8'h00, 0, 1'b0},
    // Zero bytes between all characters are dropped.
    '{"HISTORY:42",       1'b1, '{CMD_HISTORY,  16'd42,     8'd0,   7'd0},  8'h00, 0, 1'b1},
    // Digits run past the full store; the whole part still saturates.
    '{"COMMAND:",         1'b1, '{CMD_SETPOINT, 16'd0,      8'd255, 7'd99}, "1", 200, 1'b0},
    // Overlong line: the store fills up and the newline still ends it.
    '{"HISTORY:7",        1'b1, '{CMD_HISTORY,  16'd7,      8'd0,   7'd0},  "Z", 300, 1'b0},
    '{"HISTORY:\015 -0042 days", 1'b0, '0, 8'h00, 0, 1'b0},
    '{"COMMAND:\011036.6x",      1'b0, '0, 8'h00, 0, 1'b0},
    '{"ALARMS\377",              1'b0, '0, 8'h00, 0, 1'b0},
    '{"COMMAND:12.3",            1'b0, '0, 8'h00, 0, 1'b0}
  };

  // Character classes of the line decoder.
  function automatic bit is_gap_char(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

  function automatic bit is_dec_char(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic bit line_starts_with(input string tag);
    int i;
    if (line_len < tag.len()) return 1'b0;
    for (i = 0; i < tag.len(); i++) begin
      if (line_bytes[i] != tag[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Skips blanks and one sign after the prefix.
  function automatic int skip_lead(input int start, output bit neg);
    int pos;
    pos = start;
    neg = 1'b0;
    while (pos < line_len && is_gap_char(line_bytes[pos])) pos++;
    if (pos < line_len && (line_bytes[pos] == CH_PLUS || line_bytes[pos] == CH_MINUS)) begin
      neg = (line_bytes[pos] == CH_MINUS);
      pos++;
    end
    return pos;
  endfunction

  // Signed day count, saturated to 16 bits.
  function automatic logic [15:0] read_days(input int start);
    int          pos;
    bit          neg;
    int unsigned mag;
    int          v;
    pos = skip_lead(start, neg);
    mag = 0;
    while (pos < line_len && is_dec_char(line_bytes[pos])) begin
      mag = mag * 10 + (line_bytes[pos] - CH_ZERO);
      if (mag > 32768) mag = 32768;
      pos++;
    end
    if (neg) v = -int'(mag);
    else v = (mag > 32767) ? 32767 : int'(mag);
    return v[15:0];
  endfunction

  // Setpoint with two truncated hundredths digits; negative values clamp to zero.
  function automatic void read_setpoint(input int start, output logic [7:0] whole,
                                        output logic [6:0] hund);
    int          pos;
    int          k;
    bit          neg;
    int unsigned w;
    int unsigned h;
    pos = skip_lead(start, neg);
    w = 0;
    h = 0;
    while (pos < line_len && is_dec_char(line_bytes[pos])) begin
      w = w * 10 + (line_bytes[pos] - CH_ZERO);
      if (w > 256) w = 256;
      pos++;
    end
    if (pos < line_len && line_bytes[pos] == CH_DOT) begin
      pos++;
      for (k = 0; k < 2; k++) begin
        h = h * 10;
        if (pos < line_len && is_dec_char(line_bytes[pos])) begin
          h = h + (line_bytes[pos] - CH_ZERO);
          pos++;
        end else begin
          pos = line_len;
        end
      end
    end
    if (neg) begin
      w = 0;
      h = 0;
    end else if (w > 255) begin
      w = 255;
      h = 99;
    end
    whole = w[7:0];
    hund  = h[6:0];
  endfunction

  function automatic slcp_res_t decode_line();
    slcp_res_t  r;
    logic [7:0] w;
    logic [6:0] h;
    r = '0;
    r.command = CMD_UNKNOWN;
    if (line_starts_with("HISTORY:")) begin
      r.command   = CMD_HISTORY;
      r.day_count = read_days(PFX_LONG);
    end else if (line_starts_with("ALARMS")) begin
      r.command = CMD_ALARMS;
    end else if (line_starts_with("COMMAND:")) begin
      r.command = CMD_SETPOINT;
      read_setpoint(PFX_LONG, w, h);
      r.setpoint_whole      = w;
      r.setpoint_hundredths = h;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Updates the shadow line with one accepted byte.
  task automatic take_byte(input logic [7:0] b);
    slcp_res_t r;
    if (b == CH_NUL) return;
    if (b == CH_NL) begin
      r = decode_line();
      if (pinned_valid) begin
        r = pinned_res;
        pinned_valid = 1'b0;
      end
      decoded_due.push_back(r);
      line_len = 0;
    end else if (line_len < LINE_CAPACITY - 1) begin
      line_bytes[line_len] = b;
      line_len++;
    end
  endtask

  task automatic check_beat();
    slcp_res_t want;
    if (decoded_due.size() == 0) begin
      report_mismatch("result beat with no line pending");
      return;
    end
    want = decoded_due.pop_front();
    if (res_if.command !== want.command)
      report_mismatch($sformatf("command %0d, want %0d", res_if.command, want.command));
    if (res_if.day_count !== want.day_count)
      report_mismatch($sformatf("day_count %0d, want %0d",
                                res_if.day_count, $signed(want.day_count)));
    if (res_if.setpoint_whole !== want.setpoint_whole)
      report_mismatch($sformatf("setpoint_whole %0d, want %0d",
                                res_if.setpoint_whole, want.setpoint_whole));
    if (res_if.setpoint_hundredths !== want.setpoint_hundredths)
      report_mismatch($sformatf("setpoint_hundredths %0d, want %0d",
                                res_if.setpoint_hundredths, want.setpoint_hundredths));
  endtask

  // Both channels are sampled at the rising edge; input beats are taken first.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) take_byte(rx_if.rx_byte);
      if (res_if.valid && res_if.ready) check_beat();
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side stalls in random bursts, and never in the calm tail of the run.
  always @(negedge clk_i) begin
    if (calm_tail) begin
      res_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      res_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 11) == 0) begin
      res_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  task automatic hold_off(input int cycles);
    @(negedge clk_i);
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'($urandom_range(0, 255));
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Sends one byte beat; an optional typed-in result is armed for a newline.
  task automatic push_byte(input logic [7:0] b, input bit pin = 1'b0,
                           input slcp_res_t want = '0);
    if (!calm_tail && $urandom_range(0, 9) == 0) hold_off($urandom_range(1, 16));
    @(negedge clk_i);
    if (pin) begin
      pinned_res   = want;
      pinned_valid = 1'b1;
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic wait_all_decoded();
    @(negedge clk_i);
    rx_if.valid <= 1'b0;
    while (decoded_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] any_blank();
    case ($urandom_range(0, 4))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_VT;
      3: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic string prefix_by_index(input int idx);
    case (idx)
      0: return "HISTORY:";
      1: return "ALARMS";
      default: return "COMMAND:";
    endcase
  endfunction

  // Number text: blanks, sign, digits, optional fraction and trailing junk.
  task automatic send_number(input bit with_fraction);
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) push_byte(any_blank());
    case ($urandom_range(0, 3))
      2: push_byte(CH_PLUS);
      3: push_byte(CH_MINUS);
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 5))
        0: send_text("32767");
        1: send_text("32768");
        2: send_text("65536");
        3: send_text("255");
        4: send_text("256");
        default: send_text("0");
      endcase
    end else begin
      n = $urandom_range(0, 6);
      repeat (n) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    end
    if (with_fraction && $urandom_range(0, 1) == 1) begin
      push_byte(CH_DOT);
      n = $urandom_range(0, 3);
      repeat (n) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 3) == 0) push_byte(8'($urandom_range(8'h21, 8'h7E)));
  endtask

  // One random line, mostly well formed, the rest near misses and noise.
  task automatic send_random_line();
    int    kind;
    int    n;
    int    k;
    int    i;
    string tag;
    kind = $urandom_range(0, 19);
    if (kind <= 5) begin
      send_text("HISTORY:");
      send_number(1'b0);
    end else if (kind <= 10) begin
      send_text("COMMAND:");
      send_number(1'b1);
    end else if (kind <= 12) begin
      send_text("ALARMS");
      if ($urandom_range(0, 1) == 1) send_number(1'b1);
    end else if (kind == 13) begin
      // Prefix with one flipped bit.
      tag = prefix_by_index($urandom_range(0, 2));
      k = $urandom_range(0, tag.len() - 1);
      for (i = 0; i < tag.len(); i++) begin
        if (i == k) push_byte(tag[i] ^ (8'h01 << $urandom_range(0, 7)));
        else push_byte(tag[i]);
      end
      send_number(1'b1);
    end else if (kind == 14) begin
      // Line cut short inside a prefix.
      tag = prefix_by_index($urandom_range(0, 2));
      n = $urandom_range(0, tag.len() - 1);
      for (i = 0; i < n; i++) push_byte(tag[i]);
    end else if (kind <= 16) begin
      n = $urandom_range(1, 12);
      repeat (n) push_byte(8'($urandom_range(0, 255)));
    end else if (kind == 17 && $urandom_range(0, 3) == 0) begin
      // Blanks push the number across the end of the store.
      tag = ($urandom_range(0, 1) == 1) ? "HISTORY:" : "COMMAND:";
      send_text(tag);
      n = $urandom_range(100, 125);
      repeat (n) push_byte(any_blank());
      send_number(tag == "COMMAND:");
    end else begin
      n = $urandom_range(0, 3);
      repeat (n) push_byte(any_blank());
    end
    push_byte(CH_NL);
  endtask

  // Stall watchdog.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int  r;
    int  i;
    int  random_from;
    bit  paused_once;
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    res_if.ready  = 1'b0;
    paused_once   = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed lines.
    for (r = 0; r < $size(line_cases); r++) begin
      for (i = 0; i < line_cases[r].text.len(); i++) begin
        push_byte(line_cases[r].text[i]);
        if (line_cases[r].nul_mix) push_byte(CH_NUL);
      end
      for (i = line_cases[r].text.len(); i < line_cases[r].pad_to; i++)
        push_byte(line_cases[r].pad);
      push_byte(CH_NL, line_cases[r].typed, line_cases[r].want);
    end

    // Random lines; halfway through the sender waits for every result once.
    random_from = bytes_sent;
    while (bytes_sent - random_from < RANDOM_BYTES) begin
      if (!paused_once && bytes_sent - random_from >= RANDOM_BYTES / 2) begin
        wait_all_decoded();
        paused_once = 1'b1;
      end
      calm_tail = (bytes_sent - random_from >= RANDOM_BYTES - CALM_BYTES);
      send_random_line();
    end

    wait_all_decoded();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
